// File: rtl/hpq_pkg.sv
// ----------------------------------------------------------------------------
// hpq_pkg
// Types and constants shared by the min-heap priority queue files.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

  localparam int KEY_W      = 32;
  localparam int PAY_W      = 16;
  localparam int CNT_W      = 8;
  localparam int ADDR_W     = 8;
  localparam int SLOT_COUNT = 256;
  localparam int STATUS_W   = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [CNT_W-1:0] MAX_ENTRIES = 8'd255;

  // One heap slot: key and tag travel together through the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Register index, taken from paddr[2] (registers sit 4 bytes apart).
  localparam logic REG_CAPACITY_LIMIT = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_UP      = 4'b0010,
    S_DN_ROOT = 4'b0100,
    S_DN      = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/hpq_ram.sv
// ----------------------------------------------------------------------------
// hpq_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr_a,
  output logic [WIDTH-1:0]          rdata_a,
  input  wire [$clog2(DEPTH)-1:0]   raddr_b,
  output logic [WIDTH-1:0]          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// File: rtl/min_heap_priority_queue_top.sv
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top
// Binary min-heap priority queue of (key, payload) entries in slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_command selects insert or
//   extract-min; in_key and in_payload are used by insert only.
//   Result channel (out_valid/out_ready): one result per request with
//   status, extracted key and payload (zero unless an extract succeeds)
//   and the entry count after the operation.
//   APB port: capacity_limit at byte address 0, read back on prdata.
// Operation:
//   One request in flight. Errors and an insert into an empty heap answer
//   in the next cycle. An insert reads the parent, then moves its entry up
//   L levels (at most 7). An extract reads the root and the last entry,
//   then the moved-down entry sinks L levels (at most 7); it stops after
//   the root read when it takes the last entry. Each level is one slot-memory
//   read, compare and write; the moving entry lives in a register, so the
//   loop runs one level per cycle.
// Reset: heap empty, capacity_limit 255; slot memory is not cleared.
// Stall: the result register holds while out_ready is low, and no new
//   request is taken until that result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_priority_queue_top
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 255
) (
  input  wire                   clk,
  input  wire                   rst_n,
  // request channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_command,
  input  wire  [KEY_W-1:0]      in_key,
  input  wire  [PAY_W-1:0]      in_payload,
  // result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [KEY_W-1:0]      out_key,
  output logic [PAY_W-1:0]      out_payload,
  output logic [CNT_W-1:0]      out_entry_count,
  // configuration port
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [PADDR_W-1:0]    paddr,
  input  wire  [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam logic [CNT_W-1:0] CAP_LIM =
    (CAPACITY > 255) ? MAX_ENTRIES : CNT_W'(CAPACITY);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     cap_r;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  entry_t               hole_r, hole_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [KEY_W-1:0]     out_key_r, out_key_nxt;
  logic [PAY_W-1:0]     out_payload_r, out_payload_nxt;
  logic [CNT_W-1:0]     out_count_r, out_count_nxt;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr_a, ram_raddr_b;
  entry_t               ram_wdata, rd_a, rd_b;

  logic                 in_fire, cfg_wr;
  logic [CNT_W-1:0]     eff_lim, cnt_inc;
  logic [ADDR_W-1:0]    parent;
  logic [ADDR_W:0]      left_w, right_w, count_w, child_left_w;
  logic                 up_less, l_ok, r_ok;
  logic [ADDR_W-1:0]    child;
  entry_t               in_entry;

  hpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (rd_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (rd_b)
  );

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign in_entry = '{key: in_key, payload: in_payload};

  assign eff_lim  = (cap_r < CAP_LIM) ? cap_r : CAP_LIM;
  assign cnt_inc  = count_r + CNT_W'(1);
  assign parent   = pos_r >> 1;

  // Children of the hole; compared only while inside the live heap.
  assign left_w   = {pos_r, 1'b0};
  assign right_w  = left_w + (ADDR_W+1)'(1);
  assign count_w  = {1'b0, count_r};
  assign up_less  = hole_r.key < rd_a.key;
  assign l_ok     = (left_w <= count_w) && (rd_a.key < hole_r.key);
  assign r_ok     = (right_w <= count_w) &&
                    (rd_b.key < (l_ok ? rd_a.key : hole_r.key));
  assign child    = r_ok ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
  assign child_left_w = {child, 1'b0};

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    hole_nxt        = hole_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_key_nxt     = out_key_r;
    out_payload_nxt = out_payload_r;
    out_count_nxt   = out_count_r;
    ram_we          = 1'b0;
    ram_waddr       = pos_r;
    ram_wdata       = hole_r;
    ram_raddr_a     = '0;
    ram_raddr_b     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_key_nxt     = '0;
          out_payload_nxt = '0;
          out_status_nxt  = STATUS_OK;
          if (in_command == CMD_INSERT) begin
            if (count_r >= eff_lim) begin
              out_status_nxt = STATUS_FULL;
              out_count_nxt  = count_r;
              out_valid_nxt  = 1'b1;
            end else begin
              count_nxt     = cnt_inc;
              out_count_nxt = cnt_inc;
              hole_nxt      = in_entry;
              pos_nxt       = cnt_inc;
              if (count_r == '0) begin
                // first entry lands straight at the root
                ram_we        = 1'b1;
                ram_waddr     = ADDR_W'(1);
                ram_wdata     = in_entry;
                out_valid_nxt = 1'b1;
              end else begin
                ram_raddr_a = cnt_inc >> 1;
                state_nxt   = S_UP;
              end
            end
          end else begin
            if (count_r == '0) begin
              out_status_nxt = STATUS_EMPTY;
              out_count_nxt  = count_r;
              out_valid_nxt  = 1'b1;
            end else begin
              ram_raddr_a   = ADDR_W'(1);
              ram_raddr_b   = count_r;
              count_nxt     = count_r - CNT_W'(1);
              out_count_nxt = count_r - CNT_W'(1);
              state_nxt     = S_DN_ROOT;
            end
          end
        end
      end

      S_UP: begin
        ram_we = 1'b1;
        if ((pos_r == ADDR_W'(1)) || !up_less) begin
          // drop the new entry into the hole
          ram_wdata     = hole_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // pull the parent down, advance the hole one level up
          ram_wdata   = rd_a;
          pos_nxt     = parent;
          ram_raddr_a = parent >> 1;
        end
      end

      S_DN_ROOT: begin
        out_key_nxt     = rd_a.key;
        out_payload_nxt = rd_a.payload;
        hole_nxt        = rd_b;
        if (count_r == '0) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          pos_nxt     = ADDR_W'(1);
          ram_raddr_a = ADDR_W'(2);
          ram_raddr_b = ADDR_W'(3);
          state_nxt   = S_DN;
        end
      end

      S_DN: begin
        ram_we = 1'b1;
        if (!l_ok && !r_ok) begin
          ram_wdata     = hole_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          // lift the smaller child, sink the hole into its place
          ram_wdata   = r_ok ? rd_b : rd_a;
          pos_nxt     = child;
          ram_raddr_a = child_left_w[ADDR_W-1:0];
          ram_raddr_b = child_left_w[ADDR_W-1:0] + ADDR_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    hole_r        <= hole_nxt;
    out_status_r  <= out_status_nxt;
    out_key_r     <= out_key_nxt;
    out_payload_r <= out_payload_nxt;
    out_count_r   <= out_count_nxt;
  end

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= MAX_ENTRIES;
    end else if (cfg_wr) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY_LIMIT) ?
                  {{(PDATA_W-CNT_W){1'b0}}, cap_r} : '0;
  assign pready = 1'b1;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_key         = out_key_r;
  assign out_payload     = out_payload_r;
  assign out_entry_count = out_count_r;

endmodule

`default_nettype wire

// File: rtl/hpq_checker.sv
// ----------------------------------------------------------------------------
// hpq_checker
// Port-level checks for the min-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_checker
  import hpq_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire [STATUS_W-1:0]   out_status,
  input wire [KEY_W-1:0]      out_key,
  input wire [PAY_W-1:0]      out_payload,
  input wire [CNT_W-1:0]      out_entry_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) &&
    $stable(out_payload) && $stable(out_status) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // no new request while a result waits
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STATUS_OK || out_status == STATUS_FULL ||
                  out_status == STATUS_EMPTY)
    else $error("undefined status code");

  // failed requests carry no entry
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_key == '0 && out_payload == '0)
    else $error("error result carries data");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STATUS_EMPTY |-> out_entry_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind min_heap_priority_queue_top hpq_checker u_hpq_checker (.*);

`default_nettype wire

// File: sim/min_heap_priority_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_top_tb
// Self-checking bench for the min-heap priority queue.
// A heap model in the scoreboard predicts every result from the accepted
// insert and extract requests. Capacity changes go through the APB port while
// the block is idle. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------

module min_heap_priority_queue_top_tb;
  import hpq_pkg::*;

  localparam int HEAP_CAPACITY = 255;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
    logic [PAY_W-1:0]    payload;
    logic [CNT_W-1:0]    count;
  } heap_result_t;

  class heap_scoreboard;
    bit   [KEY_W-1:0] slot_key [SLOT_COUNT];
    bit   [PAY_W-1:0] slot_tag [SLOT_COUNT];
    int unsigned      fill;
    logic [CNT_W-1:0] limit;
    heap_result_t     awaited[$];
    int unsigned      mismatches;

    function new();
      fill       = 0;
      limit      = MAX_ENTRIES;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int unsigned room_limit();
      int unsigned lim;
      lim = limit;
      if (HEAP_CAPACITY < lim) lim = HEAP_CAPACITY;
      return lim;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      bit [KEY_W-1:0] k;
      bit [PAY_W-1:0] t;
      k = slot_key[a];
      t = slot_tag[a];
      slot_key[a] = slot_key[b];
      slot_tag[a] = slot_tag[b];
      slot_key[b] = k;
      slot_tag[b] = t;
    endfunction

    function void sift_up(int unsigned pos);
      while (pos > 1 && slot_key[pos] < slot_key[pos / 2]) begin
        swap_slots(pos, pos / 2);
        pos = pos / 2;
      end
    endfunction

    // Left child is tried first, so it wins a tie with the right one.
    function void sift_down(int unsigned pos);
      int unsigned best;
      forever begin
        best = pos;
        if (2 * pos <= fill && slot_key[2 * pos] < slot_key[best]) best = 2 * pos;
        if (2 * pos + 1 <= fill && slot_key[2 * pos + 1] < slot_key[best])
          best = 2 * pos + 1;
        if (best == pos) break;
        swap_slots(best, pos);
        pos = best;
      end
    endfunction

    function void note_request(logic cmd, logic [KEY_W-1:0] key, logic [PAY_W-1:0] tag);
      heap_result_t r;
      r = '0;
      r.status = STATUS_OK;
      if (cmd == CMD_INSERT) begin
        if (fill >= room_limit()) begin
          r.status = STATUS_FULL;
        end else begin
          fill++;
          slot_key[fill] = key;
          slot_tag[fill] = tag;
          sift_up(fill);
        end
      end else if (fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.key       = slot_key[1];
        r.payload   = slot_tag[1];
        slot_key[1] = slot_key[fill];
        slot_tag[1] = slot_tag[fill];
        fill--;
        sift_down(1);
      end
      r.count = CNT_W'(fill);
      awaited.push_back(r);
    endfunction

    function void compare(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
      end
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t result with no request pending: %h", $realtime, got);
        return;
      end
      want = awaited.pop_front();
      compare("status", KEY_W'(want.status), KEY_W'(got.status));
      compare("out_key", want.key, got.key);
      compare("out_payload", KEY_W'(want.payload), KEY_W'(got.payload));
      compare("entry_count", KEY_W'(want.count), KEY_W'(got.count));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_command = CMD_INSERT;
  logic [KEY_W-1:0]    in_key = '0;
  logic [PAY_W-1:0]    in_payload = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key;
  logic [PAY_W-1:0]    out_payload;
  logic [CNT_W-1:0]    out_entry_count;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  heap_scoreboard sb;
  bit             quiet = 1'b0;
  int             stall_left = 0;

  min_heap_priority_queue_top #(
    .CAPACITY(HEAP_CAPACITY)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_key         (out_key),
    .out_payload     (out_payload),
    .out_entry_count (out_entry_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Take results and stall the result channel in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_status, out_key, out_payload, out_entry_count});
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Many small and extreme keys so that ties and equal parents come up often.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return KEY_W'($urandom_range(0, 15)) ^ '1;
      3, 4, 5: return KEY_W'($urandom_range(0, 15));
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Leaves in_valid high on return; the next call or the caller drops it.
  task automatic send_request(logic cmd, logic [KEY_W-1:0] key, logic [PAY_W-1:0] tag);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    in_payload <= tag;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, key, tag);
  endtask

  task automatic set_capacity(logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY_LIMIT, 2'b00};
    pwdata  <= {(PDATA_W-CNT_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.limit = value;
    // read back in the next transfer
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.compare("capacity_limit readback", KEY_W'(value), KEY_W'(prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(logic [CNT_W-1:0] cap, int len, int insert_pct);
    set_capacity(cap);
    repeat (len)
      send_request(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_EXTRACT,
                   pick_key(), PAY_W'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty heap, extreme keys and payloads, three equal keys
    send_request(CMD_EXTRACT, '1, '1);
    send_request(CMD_INSERT, '1, '1);
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, 32'd5, 16'h1234);
    send_request(CMD_INSERT, 32'd5, 16'h4321);
    send_request(CMD_INSERT, 32'd5, 16'haaaa);
    send_request(CMD_INSERT, 32'h8000_0000, 16'h5555);
    repeat (7) send_request(CMD_EXTRACT, pick_key(), PAY_W'($urandom));

    // zero limit: every insert is refused
    set_capacity(8'd0);
    send_request(CMD_INSERT, 32'd3, 16'h0001);
    send_request(CMD_EXTRACT, '0, '0);

    set_capacity(8'd1);
    send_request(CMD_INSERT, 32'd9, 16'h0009);
    send_request(CMD_INSERT, 32'd1, 16'h0001);
    send_request(CMD_EXTRACT, '0, '0);

    // lower the limit below the fill level, then drain
    set_capacity(8'd3);
    send_request(CMD_INSERT, 32'd30, 16'h0030);
    send_request(CMD_INSERT, 32'd10, 16'h0010);
    send_request(CMD_INSERT, 32'd20, 16'h0020);
    set_capacity(8'd1);
    send_request(CMD_INSERT, 32'd0, 16'hffff);
    send_request(CMD_EXTRACT, '0, '0);
    send_request(CMD_EXTRACT, '0, '0);
    send_request(CMD_INSERT, 32'd0, 16'hffff);
    send_request(CMD_EXTRACT, '0, '0);

    // fill to the top, drain, then mixed limits
    run_phase(8'd255, 420, 85);
    run_phase(8'd255, 220, 25);
    run_phase(CNT_W'($urandom_range(8, 254)), 150, 60);
    run_phase(8'd1, 60, 50);
    run_phase(8'd0, 30, 50);
    run_phase(8'd7, 120, 55);
    run_phase(CNT_W'($urandom_range(8, 254)), 100, 80);
    run_phase(8'd2, 60, 70);
    quiet = 1'b1;
    run_phase(8'd255, 150, 55);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
